// File: hw/rtl/brp_pkg.sv
`default_nettype none
package brp_pkg;

  localparam int BUFFER_BYTES = 512;
  localparam int MAX_PACKETS  = 32;
  localparam int SLOT_BYTES   = 19;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);

  // tag stored with every buffer byte; tag zero never matches the live epoch
  localparam int EPOCH_W = 8;
  localparam int WORD_W  = 8 + EPOCH_W;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  localparam logic [15:0] SEQ_NONE        = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_DEFAULT = 16'd1000;

  localparam logic [1:0] REQ_HEADER = 2'd0;
  localparam logic [1:0] REQ_BYTE   = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_DONE_SEQ = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_NOT_STOR = 3'd3;
  localparam logic [2:0] ST_COMPLETE = 3'd4;
  localparam logic [2:0] ST_BYTE_RD  = 3'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] seq_num;
    logic [7:0]  pkt_index;
    logic [5:0]  pkt_total;
    logic [4:0]  pkt_len;
    logic [31:0] now_ms;
    logic [7:0]  byte_value;
    logic [4:0]  byte_pos;
    logic [8:0]  read_addr;
  } item_t;

endpackage
`default_nettype wire

// File: hw/rtl/brp_ram.sv
`default_nettype none
module brp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/bitmap_packet_reassembler.sv
`default_nettype none
// channel | ports                                      | transfer
// --------+--------------------------------------------+-----------------------
// in      | in_valid, in_ready, in_req_type .. in_read_addr | header, byte or read
// out     | out_valid, out_ready, out_status .. out_read_byte | one per input item
// cfg     | cfg_valid, cfg_ready, cfg_data             | idle_timeout_ms write
//
// One item per cycle unless stalled: input register, then header/byte/read logic into the
// output register, which holds the result until out_ready takes it.
// Buffer is one RAM with an epoch tag per byte; a clear bumps the epoch. After reset
// and whenever the epoch wraps (every 255th clear) a sweep of all BUFFER_BYTES (512)
// addresses retags the RAM, with in_ready low. A header sitting in the input register
// while the epoch is at its last value holds off the next transaction until it moves on.
// out_ready low stalls the output register and then the input register.
module bitmap_packet_reassembler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [15:0] in_seq_num,
  input  wire logic [7:0]  in_pkt_index,
  input  wire logic [5:0]  in_pkt_total,
  input  wire logic [4:0]  in_pkt_len,
  input  wire logic [31:0] in_now_ms,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic [4:0]  in_byte_pos,
  input  wire logic [8:0]  in_read_addr,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [2:0]  out_status,
  output logic             out_timed_out,
  output logic      [9:0]  out_message_len,
  output logic      [7:0]  out_read_byte,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  localparam int AW = brp_pkg::ADDR_W;
  localparam int EW = brp_pkg::EPOCH_W;
  localparam int WW = brp_pkg::WORD_W;
  localparam logic [10:0] BUF_LIM = 11'(brp_pkg::BUFFER_BYTES);
  localparam logic [5:0]  MAX_TOT = 6'(brp_pkg::MAX_PACKETS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(brp_pkg::BUFFER_BYTES - 1);

  brp_pkg::item_t in_r;
  logic in_v_r, in_v_nxt;

  logic [15:0] timeout_r, timeout_nxt;
  logic [15:0] cur_seq_r, cur_seq_nxt;
  logic [15:0] done_seq_r, done_seq_nxt;
  logic [31:0] map_r, map_nxt;
  logic [31:0] stamp_r, stamp_nxt;
  logic [5:0]  total_r, total_nxt;
  logic [4:0]  fl_r, fl_nxt;
  logic        win_open_r, win_open_nxt;
  logic [9:0]  win_off_r, win_off_nxt;
  logic [4:0]  win_len_r, win_len_nxt;
  logic [EW-1:0] epoch_r, epoch_nxt;
  logic        pass_r, pass_nxt;
  logic [AW-1:0] pass_cnt_r, pass_cnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  res_status;
  logic        res_timed_out;
  logic [9:0]  res_mlen;
  logic [7:0]  res_rbyte;
  logic [2:0]  status_r;
  logic        timed_out_r;
  logic [9:0]  mlen_r;
  logic [7:0]  rbyte_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;
  logic          byp_r;
  logic [WW-1:0] byp_word_r;
  logic [WW-1:0] rd_word;
  logic          rd_ok;
  logic [10:0]   raddr_ext;

  logic        in_fire, s1_go, wrap_hold;
  logic        byte_we;
  logic [10:0] byte_addr;

  // header datapath
  logic [5:0]  tot_clamp;
  logic        new_seq, tmo, dup, fits, store, full, clear_evt;
  logic [31:0] map_a, map_b, map_c, stamp_a, stamp_c, elapsed;
  logic [5:0]  tot_a, tot_b;
  logic [4:0]  fl_a, fl_b, fl_c;
  logic [15:0] cur_a, done_a;
  logic [9:0]  slot_off;
  logic [32:0] full_mask;

  assign cfg_ready = 1'b1;

  assign s1_go     = in_v_r && (!out_valid_r || out_ready);
  assign wrap_hold = in_v_r && (in_r.req_type == brp_pkg::REQ_HEADER) &&
                     (epoch_r == brp_pkg::EPOCH_MAX);
  assign in_ready  = !pass_r && (!in_v_r || s1_go) && !wrap_hold;
  assign in_fire   = in_valid && in_ready;

  // read address follows the item in the input register, re-read while it waits
  assign raddr_ext = in_fire ? {2'b00, in_read_addr} : {2'b00, in_r.read_addr};
  assign ram_raddr = raddr_ext[AW-1:0];

  assign ram_we    = pass_r || byte_we;
  assign ram_waddr = pass_r ? pass_cnt_r : byte_addr[AW-1:0];
  assign ram_wdata = pass_r ? '0 : {epoch_r, in_r.byte_value};

  brp_ram #(
    .WIDTH(WW),
    .DEPTH(brp_pkg::BUFFER_BYTES)
  ) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_word = byp_r ? byp_word_r : ram_rdata;
  assign rd_ok   = (rd_word[WW-1:8] == epoch_r) && ({2'b00, in_r.read_addr} < BUF_LIM);

  assign tot_clamp = (in_r.pkt_total > MAX_TOT) ? MAX_TOT : in_r.pkt_total;
  assign byte_addr = {1'b0, win_off_r} + {6'b0, in_r.byte_pos};

  always_comb begin
    in_v_nxt      = in_fire ? 1'b1 : (s1_go ? 1'b0 : in_v_r);
    timeout_nxt   = (cfg_valid && cfg_ready) ? cfg_data : timeout_r;
    cur_seq_nxt   = cur_seq_r;
    done_seq_nxt  = done_seq_r;
    map_nxt       = map_r;
    stamp_nxt     = stamp_r;
    total_nxt     = total_r;
    fl_nxt        = fl_r;
    win_open_nxt  = win_open_r;
    win_off_nxt   = win_off_r;
    win_len_nxt   = win_len_r;
    epoch_nxt     = epoch_r;
    pass_nxt      = pass_r;
    pass_cnt_nxt  = pass_cnt_r;
    byte_we       = 1'b0;
    clear_evt     = 1'b0;
    res_status    = brp_pkg::ST_BYTE_RD;
    res_timed_out = 1'b0;
    res_mlen      = '0;
    res_rbyte     = '0;

    new_seq   = in_r.seq_num != cur_seq_r;
    map_a     = new_seq ? '0 : map_r;
    stamp_a   = new_seq ? in_r.now_ms : stamp_r;
    tot_a     = new_seq ? tot_clamp : total_r;
    fl_a      = new_seq ? '0 : fl_r;
    elapsed   = in_r.now_ms - stamp_a;
    tmo       = (map_a != '0) && (elapsed > {16'b0, timeout_r});
    cur_a     = tmo ? brp_pkg::SEQ_NONE : in_r.seq_num;
    done_a    = tmo ? brp_pkg::SEQ_NONE : done_seq_r;
    map_b     = tmo ? '0 : map_a;
    tot_b     = tmo ? '0 : tot_a;
    fl_b      = tmo ? '0 : fl_a;
    dup       = (in_r.pkt_index < 8'd32) && map_b[in_r.pkt_index[4:0]];
    slot_off  = {5'b0, in_r.pkt_index[4:0]} * 10'(brp_pkg::SLOT_BYTES);
    fits      = ({1'b0, slot_off} + {6'b0, in_r.pkt_len}) <= BUF_LIM;
    store     = !dup && (in_r.pkt_index < {2'b00, tot_b}) && fits;
    map_c     = store ? (map_b | (32'd1 << in_r.pkt_index[4:0])) : map_b;
    fl_c      = (store && ({3'b000, tot_b} == ({1'b0, in_r.pkt_index} + 9'd1))) ?
                in_r.pkt_len : fl_b;
    stamp_c   = store ? in_r.now_ms : stamp_a;
    full_mask = (33'd1 << tot_b) - 33'd1;
    full      = {1'b0, map_c} == full_mask;

    if (s1_go) begin
      case (in_r.req_type)
        brp_pkg::REQ_HEADER: begin
          win_open_nxt = 1'b0;
          if (in_r.seq_num == done_seq_r) begin
            res_status = brp_pkg::ST_DONE_SEQ;
          end else begin
            clear_evt     = new_seq || tmo;
            res_timed_out = tmo;
            cur_seq_nxt   = cur_a;
            done_seq_nxt  = done_a;
            total_nxt     = tot_b;
            if (dup) begin
              map_nxt    = map_b;
              stamp_nxt  = stamp_a;
              fl_nxt     = fl_b;
              res_status = brp_pkg::ST_DUP;
            end else begin
              map_nxt   = map_c;
              stamp_nxt = stamp_c;
              fl_nxt    = fl_c;
              if (store) begin
                win_open_nxt = 1'b1;
                win_off_nxt  = slot_off;
                win_len_nxt  = in_r.pkt_len;
              end
              if (full) begin
                if (tot_b != '0) begin
                  res_mlen = {4'b0, tot_b - 6'd1} * 10'(brp_pkg::SLOT_BYTES) +
                             {5'b0, fl_c};
                end
                done_seq_nxt = cur_a;
                map_nxt      = '0;
                cur_seq_nxt  = brp_pkg::SEQ_NONE;
                res_status   = brp_pkg::ST_COMPLETE;
              end else begin
                res_status = store ? brp_pkg::ST_STORED : brp_pkg::ST_NOT_STOR;
              end
            end
          end
        end
        brp_pkg::REQ_BYTE: begin
          byte_we = win_open_r && (in_r.byte_pos < win_len_r) && (byte_addr < BUF_LIM);
        end
        brp_pkg::REQ_READ: begin
          res_rbyte = rd_ok ? rd_word[7:0] : '0;
        end
        default: begin
          res_status = brp_pkg::ST_BYTE_RD;
        end
      endcase
    end

    // clear = new epoch; on wrap, retag the whole RAM before taking more items
    if (pass_r) begin
      pass_cnt_nxt = pass_cnt_r + AW'(1);
      if (pass_cnt_r == LAST_ADDR) begin
        pass_nxt = 1'b0;
      end
    end else if (clear_evt) begin
      if (epoch_r == brp_pkg::EPOCH_MAX) begin
        epoch_nxt    = brp_pkg::EPOCH_FIRST;
        pass_nxt     = 1'b1;
        pass_cnt_nxt = '0;
      end else begin
        epoch_nxt = epoch_r + EW'(1);
      end
    end

    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      timeout_r   <= brp_pkg::TIMEOUT_DEFAULT;
      cur_seq_r   <= '0;
      done_seq_r  <= '0;
      map_r       <= '0;
      stamp_r     <= '0;
      total_r     <= '0;
      fl_r        <= '0;
      win_open_r  <= 1'b0;
      win_off_r   <= '0;
      win_len_r   <= '0;
      epoch_r     <= brp_pkg::EPOCH_FIRST;
      pass_r      <= 1'b1;
      pass_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      byp_r       <= 1'b0;
    end else begin
      in_v_r      <= in_v_nxt;
      timeout_r   <= timeout_nxt;
      cur_seq_r   <= cur_seq_nxt;
      done_seq_r  <= done_seq_nxt;
      map_r       <= map_nxt;
      stamp_r     <= stamp_nxt;
      total_r     <= total_nxt;
      fl_r        <= fl_nxt;
      win_open_r  <= win_open_nxt;
      win_off_r   <= win_off_nxt;
      win_len_r   <= win_len_nxt;
      epoch_r     <= epoch_nxt;
      pass_r      <= pass_nxt;
      pass_cnt_r  <= pass_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      // write and read of the same address in one cycle: forward the new word
      byp_r       <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk) begin
    byp_word_r <= ram_wdata;
    if (in_fire) begin
      in_r.req_type   <= in_req_type;
      in_r.seq_num    <= in_seq_num;
      in_r.pkt_index  <= in_pkt_index;
      in_r.pkt_total  <= in_pkt_total;
      in_r.pkt_len    <= in_pkt_len;
      in_r.now_ms     <= in_now_ms;
      in_r.byte_value <= in_byte_value;
      in_r.byte_pos   <= in_byte_pos;
      in_r.read_addr  <= in_read_addr;
    end
    if (s1_go) begin
      status_r    <= res_status;
      timed_out_r <= res_timed_out;
      mlen_r      <= res_mlen;
      rbyte_r     <= res_rbyte;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_timed_out   = timed_out_r;
  assign out_message_len = mlen_r;
  assign out_read_byte   = rbyte_r;

endmodule
`default_nettype wire
